// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/msp_pkg.sv
`timescale 1ns / 1ps
package msp_pkg;

    localparam int WEIGHT_W = 20;
    localparam int COST_W   = 22;
    localparam int VIN_W    = 9;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_START_COST   = 2'd1;
    localparam logic [1:0] CFG_FINISH_COST  = 2'd2;

    typedef enum logic [1:0] {
        UF_INIT = 2'd0,
        UF_JOIN = 2'd1,
        UF_SAME = 2'd2
    } uf_op_t;

    typedef struct packed {
        logic   valid;
        uf_op_t op;
    } uf_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic same;
    } uf_stat_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_INIT,
        FS_F_RD,
        FS_F_CHK,
        FS_C_RD,
        FS_C_CHK,
        FS_LINK
    } fs_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_Q_INIT,
        ST_Q_INIT_WAIT,
        ST_Q_RD,
        ST_Q_EDGE,
        ST_Q_JOIN_WAIT,
        ST_Q_SAME,
        ST_Q_SAME_WAIT,
        ST_Q_NEXT,
        ST_Q_DONE
    } top_state_t;

endpackage

// File: sv/msp_forest.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Union-find forest held in one synchronous memory, with path compression
module msp_forest #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  msp_pkg::uf_cmd_t                    cmd,
    input  logic [$clog2(MAX_VERTICES)-1:0]     x,
    input  logic [$clog2(MAX_VERTICES)-1:0]     y,
    input  logic [$clog2(MAX_VERTICES):0]       n,
    output msp_pkg::uf_stat_t                   stat
);
    import msp_pkg::*;

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int NW = VW + 1;

    fs_state_t state_reg, state_next;
    uf_op_t    op_reg, op_next;
    logic [VW-1:0] x_reg, x_next, y_reg, y_next;
    logic [NW-1:0] n_reg, n_next;
    logic [VW-1:0] v_reg, v_next;
    logic [VW-1:0] cur_reg, cur_next;
    logic [VW-1:0] rx_reg, rx_next;
    logic          phase_reg, phase_next;
    logic          same_reg, same_next;
    logic          done_reg, done_next;

    logic [VW-1:0] parent_mem [MAX_VERTICES];
    logic [VW-1:0] rd_data_reg;
    logic          mem_we;
    logic [VW-1:0] mem_wa, mem_wd, mem_ra;

    logic [VW-1:0] fstart;
    logic          init_last;

    assign fstart    = phase_reg ? y_reg : x_reg;
    assign init_last = (NW'(v_reg) + NW'(1)) >= n_reg;

    // Parent memory: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            parent_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= parent_mem[mem_ra];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = (cmd.op == UF_INIT) ? FS_INIT : FS_F_RD;
                end
            end
            FS_INIT:
            begin
                if (init_last)
                begin
                    state_next = FS_IDLE;
                end
            end
            FS_F_RD:  state_next = FS_F_CHK;
            FS_F_CHK:
            begin
                if (rd_data_reg == cur_reg)
                begin
                    state_next = FS_C_RD;
                end
            end
            FS_C_RD:  state_next = FS_C_CHK;
            FS_C_CHK:
            begin
                if (rd_data_reg == cur_reg)
                begin
                    state_next = phase_reg ? FS_LINK : FS_F_RD;
                end
            end
            FS_LINK:  state_next = FS_IDLE;
            default:  state_next = FS_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        v_next     = v_reg;
        cur_next   = cur_reg;
        rx_next    = rx_reg;
        phase_next = phase_reg;
        same_next  = same_reg;
        done_next  = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = v_reg;
        mem_wd     = v_reg;
        mem_ra     = cur_reg;
        unique case (state_reg)
            FS_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.op;
                    x_next     = x;
                    y_next     = y;
                    n_next     = n;
                    v_next     = '0;
                    phase_next = 1'b0;
                end
            end
            FS_INIT:
            begin
                // each vertex becomes its own root
                mem_we = 1'b1;
                v_next = v_reg + VW'(1);
                if (init_last)
                begin
                    done_next = 1'b1;
                end
            end
            FS_F_RD:
            begin
                mem_ra   = fstart;
                cur_next = fstart;
            end
            FS_F_CHK:
            begin
                // climb one parent a cycle
                mem_ra   = rd_data_reg;
                cur_next = rd_data_reg;
            end
            FS_C_RD:
            begin
                mem_ra = fstart;
                v_next = fstart;
            end
            FS_C_CHK:
            begin
                if (rd_data_reg != cur_reg)
                begin
                    // hang this node straight under the root, move up
                    mem_we = 1'b1;
                    mem_wa = v_reg;
                    mem_wd = cur_reg;
                    mem_ra = rd_data_reg;
                    v_next = rd_data_reg;
                end
                else if (!phase_reg)
                begin
                    rx_next    = cur_reg;
                    phase_next = 1'b1;
                end
            end
            FS_LINK:
            begin
                // root of second end goes under root of first end
                if (op_reg == UF_JOIN && rx_reg != cur_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = cur_reg;
                    mem_wd = rx_reg;
                end
                same_next = (rx_reg == cur_reg);
                done_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        n_reg     <= n_next;
        v_reg     <= v_next;
        cur_reg   <= cur_next;
        rx_reg    <= rx_next;
        phase_reg <= phase_next;
        same_reg  <= same_next;
    end

    assign stat.busy = (state_reg != FS_IDLE);
    assign stat.done = done_reg;
    assign stat.same = same_reg;

    `ASSERT_NEXT(a_done_pulse, stat.done, !stat.done)
    `ASSERT_IMPLY(a_cmd_when_idle, cmd.valid, state_reg == FS_IDLE)
    `ASSERT_IMPLY(a_init_range, state_reg == FS_INIT, NW'(v_reg) < n_reg)

endmodule

// File: sv/min_spread_path_union_find_top.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel    Dir  Signals                                   Beat carries
// s_axis     in   tvalid tready tdata[55:0] tuser[1:0]      edge load, query or clear
// m_axis     out  tvalid tready tdata[23:0] tuser[0]        one answer per query
// cfg        in   cfg_we cfg_index[1:0] cfg_wdata[19:0]     register write
//
// Load: an insertion shift through the edge memory (E stored edges).
// Query: per start edge a forest rebuild, then per walked edge a join (live edges only)
//   and a root check, each two compressing finds and a link.
// Clear and idle modes end without leaving idle. One item is worked at a time; s_axis_tready
// is high only while idle, and a finished answer waits in the output register for m_axis_tready.
// Reset clears control and the edge count; the memories need no clearing pass.
module min_spread_path_union_find_top #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_EDGES    = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // edge_end_a[8:0], edge_end_b[17:9], edge_weight[37:18], query_start[46:38],
    // query_finish[55:47]
    input  logic [55:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // total_cost[21:0], zero fill [23:22]
    output logic [23:0] m_axis_tdata,
    // no_path[0]
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_wdata
);
    import msp_pkg::*;

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = VW + 1;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EW  = 2 * VW + WEIGHT_W;

    // Input fields
    logic [VIN_W-1:0]    in_a, in_b, in_s, in_t;
    logic [WEIGHT_W-1:0] in_w;
    mode_t               in_mode;
    assign in_a    = s_axis_tdata[8:0];
    assign in_b    = s_axis_tdata[17:9];
    assign in_w    = s_axis_tdata[37:18];
    assign in_s    = s_axis_tdata[46:38];
    assign in_t    = s_axis_tdata[55:47];
    assign in_mode = mode_t'(s_axis_tuser);

    // Configuration
    logic [8:0]          vc_reg;
    logic [WEIGHT_W-1:0] sc_reg, fc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 9'd256;
            sc_reg <= '0;
            fc_reg <= '0;
        end
        else if (cfg_we)
        begin
            priority case (cfg_index)
                CFG_VERTEX_COUNT: vc_reg <= cfg_wdata[8:0];
                CFG_START_COST:   sc_reg <= cfg_wdata;
                CFG_FINISH_COST:  fc_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [NW-1:0] n_eff;
    assign n_eff = (32'(vc_reg) >= MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vc_reg);

    // Control and datapath registers
    top_state_t state_reg, state_next;
    logic [ECW-1:0] total_reg, total_next;
    logic [EAW-1:0] p_reg, p_next;
    logic [ECW-1:0] f_reg, f_next, i_reg, i_next;
    logic [VW-1:0]  na_reg, na_next, nb_reg, nb_next;
    logic [WEIGHT_W-1:0] nw_reg, nw_next;
    logic [VW-1:0]  s_reg, s_next, t_reg, t_next;
    logic [WEIGHT_W-1:0] ew_reg, ew_next, wf_reg, wf_next, best_reg, best_next;
    logic           found_reg, found_next;
    logic           out_valid_reg, out_valid_next;
    logic [COST_W-1:0] out_cost_reg, out_cost_next;
    logic           out_np_reg, out_np_next;

    // Edge memory
    logic [EW-1:0]  edge_mem [MAX_EDGES];
    logic [EW-1:0]  e_rd_reg;
    logic           e_we;
    logic [EAW-1:0] e_wa, e_ra;
    logic [EW-1:0]  e_wd;

    always_ff @(posedge clk)
    begin
        if (e_we)
        begin
            edge_mem[e_wa] <= e_wd;
        end
        e_rd_reg <= edge_mem[e_ra];
    end

    logic [VW-1:0]       rd_a, rd_b;
    logic [WEIGHT_W-1:0] rd_w;
    assign rd_a = e_rd_reg[EW-1 -: VW];
    assign rd_b = e_rd_reg[WEIGHT_W +: VW];
    assign rd_w = e_rd_reg[WEIGHT_W-1:0];

    // Forest
    uf_cmd_t       fcmd;
    uf_stat_t      fstat;
    logic [VW-1:0] fx, fy;

    msp_forest #(.MAX_VERTICES(MAX_VERTICES)) u_forest (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (fcmd),
        .x     (fx),
        .y     (fy),
        .n     (n_eff),
        .stat  (fstat)
    );

    // Acceptance checks
    logic in_acc, ld_ok, q_ok, edge_live;
    logic [WEIGHT_W-1:0] spread;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign ld_ok  = (32'(total_reg) < MAX_EDGES) && in_a != '0 && in_b != '0
                    && 32'(in_a) <= 32'(n_eff) && 32'(in_b) <= 32'(n_eff);
    assign q_ok   = in_s != '0 && in_t != '0
                    && 32'(in_s) <= 32'(n_eff) && 32'(in_t) <= 32'(n_eff);
    assign edge_live = (NW'(rd_a) < n_eff) && (NW'(rd_b) < n_eff);
    assign spread    = ew_reg - wf_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (in_mode == MODE_LOAD && ld_ok)
                        state_next = ST_INS_RD;
                    else if (in_mode == MODE_QUERY)
                    begin
                        if (!q_ok || total_reg == '0 || in_s == in_t)
                            state_next = ST_Q_DONE;
                        else
                            state_next = ST_Q_INIT;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_INS_RD:
            begin
                state_next = (p_reg == '0) ? ST_IDLE : ST_INS_CMP;
            end
            ST_INS_CMP:
            begin
                state_next = (rd_w > nw_reg) ? ST_INS_RD : ST_IDLE;
            end
            ST_Q_INIT:      state_next = ST_Q_INIT_WAIT;
            ST_Q_INIT_WAIT:
            begin
                if (fstat.done)
                    state_next = ST_Q_RD;
            end
            ST_Q_RD:        state_next = ST_Q_EDGE;
            ST_Q_EDGE:      state_next = edge_live ? ST_Q_JOIN_WAIT : ST_Q_SAME;
            ST_Q_JOIN_WAIT:
            begin
                if (fstat.done)
                    state_next = ST_Q_SAME;
            end
            ST_Q_SAME:      state_next = ST_Q_SAME_WAIT;
            ST_Q_SAME_WAIT:
            begin
                if (fstat.done)
                begin
                    if (fstat.same || (i_reg + ECW'(1)) == total_reg)
                        state_next = ST_Q_NEXT;
                    else
                        state_next = ST_Q_RD;
                end
            end
            ST_Q_NEXT:
            begin
                state_next = ((f_reg + ECW'(1)) == total_reg) ? ST_Q_DONE : ST_Q_INIT;
            end
            ST_Q_DONE:
            begin
                if (!out_valid_reg)
                    state_next = ST_IDLE;
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory and forest controls
    always_comb
    begin
        total_next     = total_reg;
        p_next         = p_reg;
        f_next         = f_reg;
        i_next         = i_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        nw_next        = nw_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        ew_next        = ew_reg;
        wf_next        = wf_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_cost_next  = out_cost_reg;
        out_np_next    = out_np_reg;
        e_we           = 1'b0;
        e_wa           = p_reg;
        e_wd           = {na_reg, nb_reg, nw_reg};
        e_ra           = i_reg[EAW-1:0];
        fcmd.valid     = 1'b0;
        fcmd.op        = UF_INIT;
        fx             = s_reg;
        fy             = t_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    na_next    = VW'(in_a - 9'd1);
                    nb_next    = VW'(in_b - 9'd1);
                    nw_next    = in_w;
                    s_next     = VW'(in_s - 9'd1);
                    t_next     = VW'(in_t - 9'd1);
                    p_next     = total_reg[EAW-1:0];
                    f_next     = '0;
                    best_next  = '0;
                    found_next = q_ok && total_reg != '0 && in_s == in_t;
                    if (in_mode == MODE_CLEAR)
                        total_next = '0;
                end
            end
            ST_INS_RD:
            begin
                if (p_reg == '0)
                begin
                    e_we       = 1'b1;
                    total_next = total_reg + ECW'(1);
                end
                else
                begin
                    e_ra = p_reg - EAW'(1);
                end
            end
            ST_INS_CMP:
            begin
                // shift the heavier edge up one place, or drop the new one in
                e_we = 1'b1;
                if (rd_w > nw_reg)
                begin
                    e_wd   = e_rd_reg;
                    p_next = p_reg - EAW'(1);
                end
                else
                begin
                    total_next = total_reg + ECW'(1);
                end
            end
            ST_Q_INIT:
            begin
                fcmd.valid = 1'b1;
                fcmd.op    = UF_INIT;
                i_next     = f_reg;
            end
            ST_Q_EDGE:
            begin
                ew_next = rd_w;
                if (i_reg == f_reg)
                    wf_next = rd_w;
                fx = rd_a;
                fy = rd_b;
                if (edge_live)
                begin
                    fcmd.valid = 1'b1;
                    fcmd.op    = UF_JOIN;
                end
            end
            ST_Q_SAME:
            begin
                fcmd.valid = 1'b1;
                fcmd.op    = UF_SAME;
            end
            ST_Q_SAME_WAIT:
            begin
                if (fstat.done)
                begin
                    if (fstat.same)
                    begin
                        if (!found_reg || spread < best_reg)
                            best_next = spread;
                        found_next = 1'b1;
                    end
                    i_next = i_reg + ECW'(1);
                end
            end
            ST_Q_NEXT:
            begin
                f_next = f_reg + ECW'(1);
            end
            ST_Q_DONE:
            begin
                // load the answer once the output register is free
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_np_next    = !found_reg;
                    out_cost_next  = found_reg
                        ? (COST_W'(best_reg) + COST_W'(sc_reg) + COST_W'(fc_reg))
                        : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        f_reg        <= f_next;
        i_reg        <= i_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        nw_reg       <= nw_next;
        s_reg        <= s_next;
        t_reg        <= t_next;
        ew_reg       <= ew_next;
        wf_reg       <= wf_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
        out_cost_reg <= out_cost_next;
        out_np_reg   <= out_np_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_cost_reg};
    assign m_axis_tuser  = out_np_reg;

    `ASSERT_IMPLY(a_np_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
    `ASSERT_IMPLY(a_total_bound, 1'b1, 32'(total_reg) <= MAX_EDGES)
    `ASSERT_IMPLY(a_cmd_idle, fcmd.valid, !fstat.busy)

endmodule

// File: dv/min_spread_path_union_find_top_test.sv
`timescale 1ns / 1ps
module min_spread_path_union_find_top_test;
    import msp_pkg::*;

    localparam int N_MAX      = 256;
    localparam int EDGE_CAP   = 16;
    localparam int STALL_LIMIT = 400000;

    typedef struct {
        logic [8:0]  end_a;
        logic [8:0]  end_b;
        logic [19:0] weight;
    } path_edge_t;

    typedef struct {
        logic [21:0] cost;
        logic        no_path;
    } answer_t;

    // Spread predictor and store of pending answers
    class spread_board;
        path_edge_t edges[$];
        answer_t    pending[$];
        int         vcount = 256;
        int         cost_a = 0;
        int         cost_b = 0;
        int         errors = 0;
        int         forest[N_MAX];

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
            errors++;
        endfunction

        function void set_reg(logic [1:0] idx, logic [19:0] val);
            if (idx == CFG_VERTEX_COUNT)
                vcount = val[8:0];
            else if (idx == CFG_START_COST)
                cost_a = val;
            else if (idx == CFG_FINISH_COST)
                cost_b = val;
        endfunction

        function int root(int v);
            int r;
            r = v;
            while (forest[r] != r)
                r = forest[r];
            return r;
        endfunction

        function void note_beat(logic [1:0] mode, logic [55:0] data);
            int n, s, t, ea, eb, p, best, spread, ra, rb;
            bit found, joined;
            path_edge_t e;
            answer_t ans;
            n = (vcount < N_MAX) ? vcount : N_MAX;
            if (mode == MODE_CLEAR)
            begin
                edges.delete();
            end
            else if (mode == MODE_LOAD)
            begin
                ea = data[8:0];
                eb = data[17:9];
                if (edges.size() < EDGE_CAP && ea != 0 && eb != 0 && ea <= n && eb <= n)
                begin
                    e.end_a = ea - 1;
                    e.end_b = eb - 1;
                    e.weight = data[37:18];
                    p = edges.size();
                    while (p > 0 && edges[p-1].weight > e.weight)
                        p--;
                    edges.insert(p, e);
                end
            end
            else if (mode == MODE_QUERY)
            begin
                s = data[46:38];
                t = data[55:47];
                found = 0;
                best = 0;
                if (s >= 1 && t >= 1 && s <= n && t <= n)
                begin
                    s--;
                    t--;
                    for (int f = 0; f < edges.size(); f++)
                    begin
                        for (int v = 0; v < n; v++)
                            forest[v] = v;
                        joined = (s == t);
                        spread = 0;
                        for (int i = f; i < edges.size() && !joined; i++)
                        begin
                            if (edges[i].end_a < n && edges[i].end_b < n)
                            begin
                                ra = root(edges[i].end_a);
                                rb = root(edges[i].end_b);
                                if (ra != rb)
                                    forest[rb] = ra;
                            end
                            spread = edges[i].weight - edges[f].weight;
                            joined = (root(s) == root(t));
                        end
                        if (joined && (!found || spread < best))
                        begin
                            best = spread;
                            found = 1;
                        end
                    end
                end
                ans.cost = found ? 22'(best + cost_a + cost_b) : 22'd0;
                ans.no_path = !found;
                pending.insert(pending.size(), ans);
            end
        endfunction

        function void check_beat(logic [23:0] data, logic flag);
            answer_t want;
            if (pending.size() == 0)
            begin
                report("unexpected answer", data, 0);
                return;
            end
            want = pending.pop_front();
            if (data[21:0] !== want.cost)
                report("total_cost", data[21:0], want.cost);
            if (data[23:22] !== 2'b00)
                report("tdata fill", data[23:22], 0);
            if (flag !== want.no_path)
                report("no_path", flag, want.no_path);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_wdata;

    spread_board board;
    bit  calm;
    int  quiet_cycles;
    int  n_now;

    min_spread_path_union_find_top #(.MAX_EDGES(EDGE_CAP)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Accept answers with random stalls, check each beat
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_beat(m_axis_tdata, m_axis_tuser);
        m_axis_tready <= calm || ($urandom_range(99) >= 11);
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("min_spread_path_union_find_top_test: FAIL");
            $finish;
        end
    end

    // Present one beat, hold it until accepted
    task send(logic [1:0] mode, logic [8:0] a, logic [8:0] b, logic [19:0] w,
              logic [8:0] s, logic [8:0] t);
        if (!calm && $urandom_range(99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {t, s, w, b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_beat(mode, {t, s, w, b, a});
    endtask

    task send_noise();
        logic [55:0] d;
        d = {$urandom, $urandom};
        send(2'($urandom), d[8:0], d[17:9], d[37:18], d[46:38], d[55:47]);
    endtask

    // Hold off until all answers are back and the block is idle
    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0 || !s_axis_tready)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task write_reg(logic [1:0] idx, logic [19:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
        if (idx == CFG_VERTEX_COUNT)
            n_now = val;
        @(posedge clk);
    endtask

    function logic [8:0] pick_vertex(int hi);
        return 9'($urandom_range(1, hi));
    endfunction

    // One random phase: mostly well-formed load-then-query runs
    task random_phase(int items);
        int sent, k, hi;
        sent = 0;
        while (sent < items)
        begin
            hi = (n_now > 12 && $urandom_range(3) != 0) ? 12 : n_now;
            if ($urandom_range(9) < 3)
            begin
                send(MODE_CLEAR, 0, 0, 0, 0, 0);
                sent++;
            end
            if (board.edges.size() > 14)
            begin
                send(MODE_CLEAR, 0, 0, 0, 0, 0);
                sent++;
            end
            k = $urandom_range(1, 6);
            for (int i = 0; i < k; i++)
            begin
                send(MODE_LOAD, pick_vertex(hi), pick_vertex(hi),
                     ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 40)),
                     9'($urandom), 9'($urandom));
                sent++;
            end
            k = $urandom_range(1, 4);
            for (int i = 0; i < k; i++)
            begin
                send(MODE_QUERY, 9'($urandom), 9'($urandom), 20'($urandom),
                     pick_vertex(hi), pick_vertex(hi));
                sent++;
            end
            if ($urandom_range(9) == 0)
            begin
                send_noise();
                sent++;
            end
        end
    endtask

    initial
    begin
        board = new();
        calm = 1'b0;
        quiet_cycles = 0;
        n_now = 256;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_NONE;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_VERTEX_COUNT;
        cfg_wdata = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, field extremes, bad ends, unused mode
        send(MODE_QUERY, 0, 0, 0, 1, 1);
        send(MODE_LOAD, 1, 256, 20'hFFFFF, 0, 0);
        send(MODE_LOAD, 256, 2, 0, 0, 0);
        send(MODE_LOAD, 0, 3, 5, 0, 0);
        send(MODE_LOAD, 3, 257, 5, 0, 0);
        send(MODE_LOAD, 9'h1FF, 9'h1FF, 7, 0, 0);
        send(MODE_LOAD, 2, 3, 0, 0, 0);
        send(MODE_NONE, 9'h1FF, 9'h1FF, 20'hFFFFF, 9'h1FF, 9'h1FF);
        send(MODE_QUERY, 0, 0, 0, 1, 3);
        send(MODE_QUERY, 0, 0, 0, 256, 256);
        send(MODE_QUERY, 0, 0, 0, 0, 2);
        send(MODE_QUERY, 0, 0, 0, 2, 9'h1FF);
        send(MODE_QUERY, 0, 0, 0, 1, 200);
        send(MODE_LOAD, 200, 100, 9, 0, 0);
        send(MODE_QUERY, 0, 0, 0, 100, 200);
        drain();

        // Stale edges once the vertex count shrinks, large costs
        write_reg(CFG_VERTEX_COUNT, 3);
        write_reg(CFG_START_COST, 20'hFFFFF);
        write_reg(CFG_FINISH_COST, 20'hFFFFF);
        send(MODE_QUERY, 0, 0, 0, 2, 3);
        send(MODE_QUERY, 0, 0, 0, 1, 3);
        send(MODE_QUERY, 0, 0, 0, 3, 3);
        send(MODE_QUERY, 0, 0, 0, 2, 4);
        send(MODE_CLEAR, 0, 0, 0, 0, 0);
        send(MODE_QUERY, 0, 0, 0, 2, 2);
        drain();

        // Full list: fill with ascending weights, then one load too many
        write_reg(CFG_VERTEX_COUNT, 2);
        write_reg(CFG_START_COST, 0);
        write_reg(CFG_FINISH_COST, 0);
        calm = 1'b1;
        for (int i = 0; i < EDGE_CAP; i++)
            send(MODE_LOAD, 1, 2, 20'(i + 10), 0, 0);
        send(MODE_LOAD, 1, 1, 0, 0, 0);
        send(MODE_QUERY, 0, 0, 0, 2, 2);
        send(MODE_CLEAR, 0, 0, 0, 0, 0);
        calm = 1'b0;
        drain();

        // Random phases across settings, one phase with no idling
        write_reg(CFG_VERTEX_COUNT, 1);
        random_phase(6);
        drain();
        write_reg(CFG_VERTEX_COUNT, 8);
        write_reg(CFG_START_COST, 20'($urandom));
        write_reg(CFG_FINISH_COST, 20'($urandom_range(0, 100)));
        random_phase(15);
        drain();
        calm = 1'b1;
        write_reg(CFG_VERTEX_COUNT, 5);
        random_phase(12);
        calm = 1'b0;
        drain();
        write_reg(CFG_VERTEX_COUNT, 256);
        write_reg(CFG_START_COST, 0);
        write_reg(CFG_FINISH_COST, 20'hFFFFF);
        random_phase(20);
        drain();
        repeat (50) @(posedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("min_spread_path_union_find_top_test: PASS");
        else
            $display("min_spread_path_union_find_top_test: FAIL");
        $finish;
    end
endmodule
